// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/elf_pkg.sv =====
// shared types and constants of the escaped line framer
package elf_pkg;

    localparam int NRES    = 6;
    localparam int IDX_W   = 3;

    localparam logic [7:0] C_SOH = 8'h01;
    localparam logic [7:0] C_ETX = 8'h03;
    localparam logic [7:0] C_ESC = 8'h1B;
    localparam logic [7:0] C_XOR = 8'hFF;
    localparam logic [7:0] C_CR  = 8'h0D;
    localparam logic [7:0] C_LF  = 8'h0A;

    localparam logic [8:0] LINE_MAX      = 9'd256;
    localparam logic [9:0] ESC_COUNT_MAX = 10'd1023;
    localparam logic [9:0] LIMIT_RESET   = 10'd278;

    typedef struct packed {
        logic       line_open;
        logic [8:0] char_count;
        logic [9:0] escaped_count;
    } t_state;

    typedef struct packed {
        logic [NRES-1:0][7:0] bytes;
        logic [IDX_W-1:0]     count;
    } t_bundle;

endpackage

// ===== rtl/elf_encode.sv =====
// framing and escaping of one input byte into a bundle of output bytes
module elf_encode (
    input  logic [7:0]      i_byte,
    input  elf_pkg::t_state i_state,
    input  logic [9:0]      i_limit,
    output elf_pkg::t_bundle o_bundle,
    output elf_pkg::t_state o_state
);
    import elf_pkg::*;

    always_comb begin
        logic [NRES-1:0][7:0] b;
        logic [IDX_W-1:0]     n;
        logic [9:0]           esc;
        logic [10:0]          esc_sum;
        logic [8:0]           cc;
        logic                 close_now;

        b         = '0;
        n         = '0;
        esc       = i_state.escaped_count;
        esc_sum   = '0;
        cc        = i_state.char_count;
        close_now = 1'b0;
        o_state   = i_state;

        if (i_byte != C_CR) begin
            // open a frame on the first byte of a line
            if (!i_state.line_open) begin
                b[n] = C_SOH;
                n    = n + 3'd1;
                esc  = '0;
            end

            if (i_byte == C_LF) begin
                close_now = 1'b1;
            end else begin
                if (esc < i_limit) begin
                    if (i_byte == C_SOH || i_byte == C_ETX || i_byte == C_ESC) begin
                        b[n]    = C_ESC;
                        n       = n + 3'd1;
                        b[n]    = i_byte ^ C_XOR;
                        n       = n + 3'd1;
                        esc_sum = {1'b0, esc} + 11'd2;
                    end else begin
                        b[n]    = i_byte;
                        n       = n + 3'd1;
                        esc_sum = {1'b0, esc} + 11'd1;
                    end
                    // saturate the escaped count
                    esc = (esc_sum > {1'b0, ESC_COUNT_MAX}) ? ESC_COUNT_MAX : esc_sum[9:0];
                end
                cc = cc + 9'd1;
                if (cc >= LINE_MAX) begin
                    close_now = 1'b1;
                end
            end

            if (close_now) begin
                b[n] = C_ETX;
                n    = n + 3'd1;
                b[n] = C_CR;
                n    = n + 3'd1;
                b[n] = C_LF;
                n    = n + 3'd1;
                o_state.line_open     = 1'b0;
                o_state.char_count    = '0;
                o_state.escaped_count = '0;
            end else begin
                o_state.line_open     = 1'b1;
                o_state.char_count    = cc;
                o_state.escaped_count = esc;
            end
        end

        o_bundle.bytes = b;
        o_bundle.count = n;
    end

endmodule

// ===== rtl/elf_serial.sv =====
// result register holding one bundle and sending it out a beat at a time
module elf_serial (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  elf_pkg::t_bundle i_bundle,
    output logic             o_free,
    output logic             o_tvalid,
    input  logic             i_tready,
    output logic [7:0]       o_tdata,
    output logic             o_tlast
);
    import elf_pkg::*;

    logic             r_valid, n_valid;
    t_bundle          r_bundle, n_bundle;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             last_beat;

    assign last_beat = (r_idx == r_bundle.count - 3'd1);
    assign o_free    = !r_valid || (i_tready && last_beat);
    assign o_tvalid  = r_valid;
    assign o_tdata   = r_bundle.bytes[r_idx];
    assign o_tlast   = last_beat;

    always_comb begin
        n_valid  = r_valid;
        n_bundle = r_bundle;
        n_idx    = r_idx;
        if (r_valid && i_tready) begin
            if (last_beat) begin
                n_valid = 1'b0;
            end else begin
                n_idx = r_idx + 3'd1;
            end
        end
        if (i_load) begin
            n_valid  = 1'b1;
            n_bundle = i_bundle;
            n_idx    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
        r_bundle <= n_bundle;
    end

endmodule

// ===== rtl/escaped_line_framer.sv =====
// top level of the escaped line framer
//
// slave stream s_axis carries one raw text byte per beat; master stream
// m_axis carries the framed bytes, tlast marking the final byte that one
// input byte caused. content_limit is written on the cfg channel, which
// is always ready; write it only while the block is idle.
//
// an accepted byte is framed and escaped in the same cycle and lands in
// the result register, so its first output beat shows in the next cycle.
// each input byte gives zero to five output beats, one per cycle while
// the receiver is ready: the result register and its beat index set the
// rate, so no new input byte is taken while earlier beats are pending,
// and a byte with no output (carriage return, skipped content) leaves
// the result register untouched. the next input is taken in the cycle
// the last pending beat leaves.
//
// synchronous active-low reset clears the line state, drops any pending
// beats and sets content_limit to 278. a stalled receiver holds the
// current beat and, once its bundle is waiting, holds s_axis_tready low.
module escaped_line_framer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [9:0] i_cfg_data
);
    import elf_pkg::*;

    logic [9:0] r_limit;
    t_state     r_state, n_state;
    t_bundle    enc_bundle;
    logic       accept;
    logic       load;
    logic       free;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    // a byte with no output leaves the result register untouched
    assign load          = accept && (enc_bundle.count != '0);

    elf_encode u_encode (
        .i_byte   (s_axis_tdata),
        .i_state  (r_state),
        .i_limit  (r_limit),
        .o_bundle (enc_bundle),
        .o_state  (n_state)
    );

    elf_serial u_serial (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_bundle (enc_bundle),
        .o_free   (free),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

    // line state advances on every accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // content limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_limit <= i_cfg_data;
        end
    end

endmodule

// ===== rtl/elf_checker.sv =====
// port-level checks of the escaped line framer and their binding
`include "assert_macros.svh"

module elf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);
    import elf_pkg::*;

    logic nl_beat;
    assign nl_beat = s_axis_tvalid && s_axis_tready && (s_axis_tdata == C_LF);

    // a stalled output beat holds
    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // no new input while a bundle still has beats after the current one
    `ASSERT_IMP(a_no_take_mid, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast,
        !s_axis_tready)

    // a newline always gives output starting with a frame open or close byte
    `ASSERT_NXT(a_nl_out, i_clk, i_rst_n, nl_beat,
        m_axis_tvalid && !m_axis_tlast &&
        (m_axis_tdata == C_SOH || m_axis_tdata == C_ETX))

endmodule

bind escaped_line_framer elf_checker u_elf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/sv/escaped_line_framer_tb.sv =====
// self-checking testbench of the escaped line framer: line predictor, scoreboard and drivers
`timescale 1ns / 100ps

module escaped_line_framer_tb;
    import elf_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_framed_beat;

    // predicts the framed beats of each accepted text byte and checks the output stream
    class framer_scoreboard;
        logic [9:0]   content_limit;
        logic         line_open;
        logic [8:0]   char_count;
        logic [9:0]   escaped_count;
        t_framed_beat expected_beats[$];
        int           error_count;
        int           beats_checked;
        int           bytes_noted;

        function void clear();
            content_limit = LIMIT_RESET;
            line_open     = 1'b0;
            char_count    = '0;
            escaped_count = '0;
            expected_beats.delete();
            error_count   = 0;
            beats_checked = 0;
            bytes_noted   = 0;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        function void bump_escaped(input logic [1:0] add);
            logic [10:0] sum;
            sum = {1'b0, escaped_count} + 11'(add);
            escaped_count = (sum > 11'(ESC_COUNT_MAX)) ? ESC_COUNT_MAX : sum[9:0];
        endfunction

        function void note_text_byte(input logic [7:0] c);
            logic [7:0]   burst[$];
            logic         close_now;
            t_framed_beat beat;
            close_now = 1'b0;
            bytes_noted++;
            if (c == C_CR)
                return;
            if (!line_open) begin
                burst.push_back(C_SOH);
                line_open     = 1'b1;
                escaped_count = '0;
            end
            if (c == C_LF) begin
                close_now = 1'b1;
            end else begin
                // content is taken whole while the count is still below the limit
                if (escaped_count < content_limit) begin
                    if (c == C_SOH || c == C_ETX || c == C_ESC) begin
                        burst.push_back(C_ESC);
                        burst.push_back(c ^ C_XOR);
                        bump_escaped(2'd2);
                    end else begin
                        burst.push_back(c);
                        bump_escaped(2'd1);
                    end
                end
                char_count = char_count + 9'd1;
                if (char_count >= LINE_MAX)
                    close_now = 1'b1;
            end
            if (close_now) begin
                burst.push_back(C_ETX);
                burst.push_back(C_CR);
                burst.push_back(C_LF);
                line_open     = 1'b0;
                char_count    = '0;
                escaped_count = '0;
            end
            foreach (burst[i]) begin
                beat.data = burst[i];
                beat.last = (i == burst.size() - 1);
                expected_beats.push_back(beat);
            end
        endfunction

        function void check_framed_beat(input logic [7:0] data, input logic last);
            t_framed_beat want;
            beats_checked++;
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat, got data %02h last %0b", $time, data, last);
                error_count++;
                return;
            end
            want = expected_beats.pop_front();
            if (data !== want.data) begin
                $display("%0t: data mismatch, expected %02h, got %02h",
                         $time, want.data, data);
                error_count++;
            end
            if (last !== want.last) begin
                $display("%0t: tlast mismatch, expected %0b, got %0b",
                         $time, want.last, last);
                error_count++;
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT  = 600000;
    // idle cycles after the drain, before the configuration changes
    localparam int DRAIN_CYCLES = 4;

    logic       i_clk;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;    // [7:0] in_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;    // [7:0] out_byte
    logic       m_axis_tlast;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [9:0] i_cfg_data;

    framer_scoreboard sb;
    int cycle_count = 0;
    int limit_writes;
    int ready_hold = 0;

    escaped_line_framer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d beats still expected", $time, sb.pending());
            $display("escaped_line_framer_tb: done, errors");
            $finish;
        end
    end

    // receiver: ready stretches of random length, mostly short stalls and a few long ones
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (!m_axis_tready) begin
            m_axis_tready <= 1'b1;
            ready_hold    <= ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                         : $urandom_range(0, 12);
        end else begin
            m_axis_tready <= 1'b0;
            ready_hold    <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(0, 2);
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_framed_beat(m_axis_tdata, m_axis_tlast);
    end

    function automatic int pick_gap(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [7:0] pick_escape_code();
        case ($urandom_range(0, 2))
            0:       return C_SOH;
            1:       return C_ETX;
            default: return C_ESC;
        endcase
    endfunction

    function automatic logic [7:0] pick_text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 8'($urandom_range(8'h20, 8'h7e));
        if (r < 72)
            return pick_escape_code();
        if (r < 78)
            return C_CR;
        if (r < 81)
            return C_LF;
        return 8'($urandom_range(0, 255));
    endfunction

    // one input beat; valid stays high when the next byte follows back to back
    task automatic send_text_byte(input logic [7:0] b, input int gap);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_text_byte(b);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // sender holds off until every expected beat is out and the block has settled
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [9:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.content_limit = value;
        limit_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // lines of random content, mostly newline-terminated, some left open
    task automatic run_random_phase(input logic [9:0] value, input int item_goal);
        int  sent;
        int  len;
        bit  burst;
        sent = 0;
        write_limit(value);
        while (sent < item_goal) begin
            burst = ($urandom_range(0, 3) == 0);
            len   = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
            if (len > item_goal - sent)
                len = item_goal - sent;
            repeat (len) begin
                send_text_byte(pick_text_byte(), pick_gap(burst));
                sent++;
            end
            if ($urandom_range(0, 99) < 85) begin
                send_text_byte(C_LF, pick_gap(burst));
                sent++;
            end
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end
    endtask

    initial begin
        logic [7:0] directed_reset[$];
        logic [7:0] b;
        sb = new();
        sb.clear();
        limit_writes  = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset limit: field extremes, every escape code, cr inside and outside a line,
        // newline on an unopened line, neighbors of the control codes
        directed_reset = '{8'h48, 8'h00, 8'hff, C_SOH, C_ETX, C_ESC, C_CR, C_LF,
                           C_LF, C_CR, 8'h02, 8'hfe, 8'h1a, 8'h1c, 8'h04, 8'h80, C_LF};
        foreach (directed_reset[i])
            send_text_byte(directed_reset[i], pick_gap(1'b0));

        // escape pair emitted whole at the limit, then content skipped until the newline
        write_limit(10'd3);
        send_text_byte(8'h61, 0);
        send_text_byte(8'h62, 0);
        send_text_byte(C_ESC, 0);
        send_text_byte(8'h63, 1);
        send_text_byte(C_LF, 0);

        // zero limit: frames still open and close around no content
        write_limit(10'd0);
        send_text_byte(8'h78, 0);
        send_text_byte(C_SOH, 2);
        send_text_byte(C_LF, 0);

        run_random_phase(10'd1, 3);
        run_random_phase(10'd1023, 3);
        run_random_phase(10'($urandom_range(2, 16)), 3);
        run_random_phase(10'($urandom_range(1, 1023)), 3);
        run_random_phase(LIMIT_RESET, 3);

        // overlong line: escapes push the count past the limit, then the line
        // closes itself at the maximum length on a skipped byte
        write_limit(10'd300);
        repeat (256) begin
            if ($urandom_range(0, 99) < 30) begin
                b = pick_escape_code();
            end else begin
                b = 8'($urandom_range(0, 255));
                if (b == C_LF || b == C_CR)
                    b = 8'h55;
            end
            send_text_byte(b, pick_gap(1'($urandom_range(0, 1))));
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d expected beats never arrived", $time, sb.pending());
            sb.error_count++;
        end
        $display("covered %0d text bytes and %0d framed beats under %0d limit writes,",
                 sb.bytes_noted, sb.beats_checked, limit_writes);
        $display("limits 0, 1, 3, 300 and 1023 among them, with an overlong line");
        if (sb.error_count == 0) begin
            $display("escaped_line_framer_tb: done, clean");
        end else begin
            $display("escaped_line_framer_tb: done, errors");
        end
        $finish;
    end

endmodule
